>>> rtl/hpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_pkg
// Request and response types, mode codes and status codes for the handle pool
// allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

    // request modes
    localparam logic [1:0] MODE_ALLOC     = 2'd0;
    localparam logic [1:0] MODE_TRY_ALLOC = 2'd1;
    localparam logic [1:0] MODE_RELEASE   = 2'd2;
    localparam logic [1:0] MODE_IGNORED   = 2'd3;

    // response status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NONE_FREE = 2'd1;
    localparam logic [1:0] STATUS_INVALID   = 2'd2;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] release_handle;
    } req_t;

    typedef struct packed {
        logic [7:0] granted_handle;
        logic [1:0] status;
    } rsp_t;

endpackage

>>> rtl/handle_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_allocator
// Hands out handles 0 to POOL_SIZE-1: reuses the oldest released handle from
// a free queue, else (allocate mode only) issues a fresh one; releases are
// checked against a per-handle used mark and queued.
//
//   channel | ports                  | direction | contents
//   --------+------------------------+-----------+--------------------------
//   request | s_valid s_ready s_data | in        | mode, release_handle
//   result  | m_valid m_ready m_data | out       | granted_handle, status
//
// Each request has a read step on the free queue and used-mark memories
// (synchronous read), then a decide step that writes back.
// A new request is taken once the previous one has written back.
// Reset clears state, valid flag, counters and pointers only; used marks above
// the fresh count read as clear, so no clearing pass is needed.
// A stalled result waits in the output register; the decide step holds until
// that register is free.
// ----------------------------------------------------------------------------
module handle_pool_allocator #(
    parameter int POOL_SIZE = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hpa_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output hpa_pkg::rsp_t m_data
);

    localparam int HW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int EW = (HW > 8) ? HW : 8;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_LOOKUP = 1'b1;

    localparam logic [HW-1:0] LAST_POS  = HW'(POOL_SIZE - 1);
    localparam logic [CW-1:0] POOL_CNT  = CW'(POOL_SIZE);
    localparam logic [EW:0]   POOL_EXT  = (EW + 1)'(POOL_SIZE);

    // memories: free queue and used marks, no reset
    logic [HW-1:0] queue_mem [POOL_SIZE];
    logic          mark_mem  [POOL_SIZE];

    logic          state_reg, state_next;
    logic [HW-1:0] head_reg, head_next;
    logic [HW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic          m_valid_reg, m_valid_next;
    hpa_pkg::rsp_t m_data_reg, m_data_next;

    logic [1:0]    mode_reg;
    logic [7:0]    rel_reg;
    logic [HW-1:0] q_rdata_reg;
    logic          mark_rdata_reg;

    logic          s_fire;
    logic          out_free;
    logic          finish;
    logic [EW-1:0] rel_ext;
    logic [HW-1:0] rel_idx;
    logic [EW-1:0] rel_ext_in;
    logic [HW-1:0] rel_idx_in;
    logic          rel_ok;

    logic          mark_we;
    logic [HW-1:0] mark_waddr;
    logic          mark_wdata;
    logic          queue_we;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_LOOKUP) && out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // release handle fitted to the internal handle width
    assign rel_ext_in = EW'(s_data.release_handle);
    assign rel_idx_in = rel_ext_in[HW-1:0];
    assign rel_ext    = EW'(rel_reg);
    assign rel_idx    = rel_ext[HW-1:0];

    // a mark is only meaningful below the fresh count
    assign rel_ok = ({1'b0, rel_ext} < POOL_EXT)
                 && (CW'(rel_idx) < fresh_reg)
                 && mark_rdata_reg
                 && (count_reg < POOL_CNT);

    // request capture and memory reads
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg       <= s_data.mode;
            rel_reg        <= s_data.release_handle;
            q_rdata_reg    <= queue_mem[head_reg];
            mark_rdata_reg <= mark_mem[rel_idx_in];
        end
    end

    // memory write back
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (queue_we) begin
            queue_mem[tail_reg] <= rel_idx;
        end
    end

    // decide step
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mark_we      = 1'b0;
        mark_waddr   = rel_idx;
        mark_wdata   = 1'b0;
        queue_we     = 1'b0;

        if (s_fire) begin
            state_next = S_LOOKUP;
        end

        if (finish) begin
            state_next                 = S_IDLE;
            m_valid_next               = 1'b1;
            m_data_next.granted_handle = 8'd0;
            m_data_next.status         = hpa_pkg::STATUS_OK;

            case (mode_reg)
                hpa_pkg::MODE_ALLOC, hpa_pkg::MODE_TRY_ALLOC: begin
                    if (count_reg != '0) begin
                        // reuse oldest released handle
                        m_data_next.granted_handle = 8'(q_rdata_reg);
                        head_next  = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        mark_we    = 1'b1;
                        mark_waddr = q_rdata_reg;
                        mark_wdata = 1'b1;
                    end else if (mode_reg == hpa_pkg::MODE_TRY_ALLOC) begin
                        m_data_next.status = hpa_pkg::STATUS_NONE_FREE;
                    end else if (fresh_reg < POOL_CNT) begin
                        // issue next fresh handle
                        m_data_next.granted_handle = 8'(fresh_reg[HW-1:0]);
                        fresh_next = fresh_reg + 1'b1;
                        mark_we    = 1'b1;
                        mark_waddr = fresh_reg[HW-1:0];
                        mark_wdata = 1'b1;
                    end else begin
                        m_data_next.status = hpa_pkg::STATUS_EXHAUSTED;
                    end
                end
                hpa_pkg::MODE_RELEASE: begin
                    if (rel_ok) begin
                        mark_we    = 1'b1;
                        mark_waddr = rel_idx;
                        mark_wdata = 1'b0;
                        queue_we   = 1'b1;
                        tail_next  = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        m_data_next.status = hpa_pkg::STATUS_INVALID;
                    end
                end
                default: begin
                    m_data_next.status = hpa_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

>>> tb/sv/handle_pool_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_checker
// Watches the request and result channels of the handle pool allocator. It
// keeps its own copy of the pool (used marks, free FIFO, fresh handle count),
// predicts the result of every accepted request and compares each accepted
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module handle_pool_checker #(
    parameter int POOL_SIZE = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  hpa_pkg::req_t s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  hpa_pkg::rsp_t m_data,
    output int            err_count,
    output int            pending,
    output logic [255:0]  used_view
);

    // pool copy
    logic [255:0]  used_marks;
    logic [7:0]    free_fifo[$];
    int unsigned   fresh_issued;

    // predicted results, oldest first
    hpa_pkg::rsp_t grant_expect_q[$];

    // pop the oldest released handle and mark it used
    function automatic logic [7:0] reuse_handle();
        logic [7:0] h;
        h = free_fifo.pop_front();
        used_marks[h] = 1'b1;
        return h;
    endfunction

    // next result of the pool for one request, updating the pool copy
    function automatic hpa_pkg::rsp_t predict_grant(hpa_pkg::req_t r);
        hpa_pkg::rsp_t p;
        p.granted_handle = '0;
        p.status         = hpa_pkg::STATUS_OK;
        case (r.mode)
            hpa_pkg::MODE_ALLOC: begin
                if (free_fifo.size() != 0) begin
                    p.granted_handle = reuse_handle();
                end else if (fresh_issued < POOL_SIZE) begin
                    p.granted_handle = fresh_issued[7:0];
                    used_marks[fresh_issued[7:0]] = 1'b1;
                    fresh_issued++;
                end else begin
                    p.status = hpa_pkg::STATUS_EXHAUSTED;
                end
            end
            hpa_pkg::MODE_TRY_ALLOC: begin
                if (free_fifo.size() != 0)
                    p.granted_handle = reuse_handle();
                else
                    p.status = hpa_pkg::STATUS_NONE_FREE;
            end
            hpa_pkg::MODE_RELEASE: begin
                if (r.release_handle >= POOL_SIZE || !used_marks[r.release_handle] ||
                    free_fifo.size() >= POOL_SIZE) begin
                    p.status = hpa_pkg::STATUS_INVALID;
                end else begin
                    used_marks[r.release_handle] = 1'b0;
                    free_fifo.push_back(r.release_handle);
                end
            end
            default: ; // unused mode: no effect
        endcase
        return p;
    endfunction

    // predict on request transfers, compare on result transfers
    always @(posedge aclk) begin
        hpa_pkg::rsp_t exp_rsp;
        int            errs;
        errs = err_count;
        if (!aresetn) begin
            errs         = 0;
            used_marks   = '0;
            free_fifo.delete();
            fresh_issued = 0;
            grant_expect_q.delete();
        end else begin
            if (s_valid && s_ready)
                grant_expect_q.push_back(predict_grant(s_data));
            if (m_valid && m_ready) begin
                if (grant_expect_q.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    errs++;
                end else begin
                    exp_rsp = grant_expect_q.pop_front();
                    if (m_data.granted_handle !== exp_rsp.granted_handle) begin
                        $error("granted_handle: expected %0d, got %0d",
                               exp_rsp.granted_handle, m_data.granted_handle);
                        errs++;
                    end
                    if (m_data.status !== exp_rsp.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_rsp.status, m_data.status);
                        errs++;
                    end
                end
            end
        end
        err_count <= errs;
        pending   <= grant_expect_q.size();
        used_view <= used_marks;
    end

endmodule

>>> tb/sv/handle_pool_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_allocator_tb
// Drives the handle pool allocator with a directed sequence covering empty
// pool, stale and never-issued releases, reuse order and the unused mode,
// then with random phases that fill the pool to exhaustion and drain it.
// Both channels idle at random; the receiver once holds off for a long
// stretch. Checking is done by handle_pool_checker.
// ----------------------------------------------------------------------------
module handle_pool_allocator_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    hpa_pkg::req_t s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    hpa_pkg::rsp_t m_data;

    int            err_count;
    int            pending;
    logic [255:0]  used_view;

    int            cycles    = 0;
    bit            steady    = 1'b0;
    bit            want_hold = 1'b0;

    always #5 aclk = ~aclk;

    handle_pool_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    handle_pool_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .err_count (err_count),
        .pending   (pending),
        .used_view (used_view)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // mostly a handle currently in use, sometimes any handle
    function automatic logic [7:0] pick_release();
        int start;
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        start = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++)
            if (used_view[(start + i) % 256]) return 8'((start + i) % 256);
        return 8'(start);
    endfunction

    // one request transfer, then a random gap
    task automatic send_req(input logic [1:0] mode, input logic [7:0] handle);
        int gap;
        s_data.mode           <= mode;
        s_data.release_handle <= handle;
        s_valid               <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // random requests with weights for allocate, try allocate and release
    task automatic random_phase(input int n, input int w_alloc, input int w_try,
                                input int w_rel);
        int          r;
        logic [1:0]  mode;
        logic [7:0]  handle;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < w_alloc)                     mode = hpa_pkg::MODE_ALLOC;
            else if (r < w_alloc + w_try)        mode = hpa_pkg::MODE_TRY_ALLOC;
            else if (r < w_alloc + w_try + w_rel) mode = hpa_pkg::MODE_RELEASE;
            else                                 mode = hpa_pkg::MODE_IGNORED;
            handle = (mode == hpa_pkg::MODE_RELEASE) ? pick_release()
                                                     : 8'($urandom_range(0, 255));
            send_req(mode, handle);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (want_hold && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("handle_pool_allocator_tb: errors");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pool, never-issued and stale releases, reuse order
        send_req(hpa_pkg::MODE_TRY_ALLOC, 8'h00);
        send_req(hpa_pkg::MODE_RELEASE,   8'hFF);
        send_req(hpa_pkg::MODE_RELEASE,   8'h00);
        send_req(hpa_pkg::MODE_ALLOC,     8'hFF);
        send_req(hpa_pkg::MODE_ALLOC,     8'h00);
        send_req(hpa_pkg::MODE_RELEASE,   8'h00);
        send_req(hpa_pkg::MODE_RELEASE,   8'h00);
        send_req(hpa_pkg::MODE_TRY_ALLOC, 8'hFF);
        send_req(hpa_pkg::MODE_IGNORED,   8'hFF);
        send_req(hpa_pkg::MODE_ALLOC,     8'h55);
        send_req(hpa_pkg::MODE_RELEASE,   8'h01);
        send_req(hpa_pkg::MODE_RELEASE,   8'h02);
        send_req(hpa_pkg::MODE_RELEASE,   8'h55);
        send_req(hpa_pkg::MODE_RELEASE,   8'hAA);
        send_req(hpa_pkg::MODE_ALLOC,     8'h00);
        send_req(hpa_pkg::MODE_TRY_ALLOC, 8'h00);
        send_req(hpa_pkg::MODE_TRY_ALLOC, 8'h00);
        send_req(hpa_pkg::MODE_IGNORED,   8'h00);
        send_req(hpa_pkg::MODE_ALLOC,     8'hAA);

        // random: back to back first, then fill to exhaustion, drain, mix
        steady = 1'b1;
        random_phase(100, 35, 20, 40);
        steady = 1'b0;
        random_phase(200, 35, 20, 40);
        want_hold = 1'b1;
        random_phase(350, 80, 5, 12);
        random_phase(200, 15, 15, 65);
        random_phase(150, 35, 20, 40);
        s_valid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("handle_pool_allocator_tb: clean");
        else
            $display("handle_pool_allocator_tb: errors");
        $finish;
    end

endmodule
